// File: rtl/mclf_pkg.sv
// Shared command codes and arithmetic constants for the LED fade ramp block.
package mclf_pkg;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_e;

  localparam int unsigned SPEED_FULL = 1023;
  localparam int unsigned SPEED_GAIN = 12;
  localparam int unsigned SPEED_W    = 10;
  localparam int unsigned SUM_W      = 17;
  localparam int unsigned DEN_W      = 14;
  localparam int unsigned QUO_W      = 16;
  localparam int unsigned NUM_W      = 26;

endpackage

// File: rtl/multi_channel_led_fade_ramp.sv
// Multi-channel LED fade ramp with potentiometer speed scaling and a bit-serial divider.
// A set command, a sample command that does not complete a group and an unused code are handled in the idle state.
// A sample that completes a group runs the divider, one quotient bit per cycle, to update the speed value.
// A tick walks every channel through ST_EVAL and ST_EMIT, plus ST_DIV for each channel that steps and reloads.
// Results leave through a one-entry register.
// Reset clears all channels, the sample sum and count and the speed value.
module multi_channel_led_fade_ramp #(
  parameter int CHANNELS           = 6,
  parameter int SAMPLES_PER_UPDATE = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [2:0]  lamp_index_i,
  input  logic [7:0]  level_in_i,
  input  logic [7:0]  target_in_i,
  input  logic [15:0] reload_in_i,
  input  logic [11:0] pot_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  lamp_out_o,
  output logic [7:0]  level_out_o,
  output logic        level_changed_o,
  output logic        last_result_o
);
  import mclf_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = (SAMPLES_PER_UPDATE > 1) ? $clog2(SAMPLES_PER_UPDATE + 1) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_AVG,
    ST_EMIT
  } state_e;

  state_e state_q;

  logic [7:0]  level_q  [CHANNELS];
  logic [7:0]  target_q [CHANNELS];
  logic [15:0] cd_q     [CHANNELS];
  logic [15:0] reload_q [CHANNELS];

  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   count_q;
  logic [SPEED_W-1:0] speed_q;
  logic [CH_W-1:0]    ch_q;
  logic               changed_q;

  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] div_q;
  logic [QUO_W-1:0] quo_q;
  logic [3:0]       bit_q;

  logic             out_valid_q;
  logic [2:0]       lamp_out_q;
  logic [7:0]       level_out_q;
  logic             level_changed_q;
  logic             last_result_q;

  logic             in_accept;
  logic             out_free;
  logic [SUM_W-1:0] sum_new;
  logic [CNT_W:0]   count_new;
  logic [NUM_W-1:0] num_sample;
  logic [NUM_W-1:0] num_reload;
  logic [DEN_W-1:0] den_speed;
  logic [DEN_W:0]   trial;
  logic             trial_ge;
  logic [DEN_W:0]   trial_diff;
  logic [7:0]       cur_level;
  logic [7:0]       cur_target;
  logic [15:0]      cur_cd;
  logic             ch_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign sum_new    = sum_q + SUM_W'(pot_sample_i);
  assign count_new  = {1'b0, count_q} + (CNT_W + 1)'(1);
  assign num_sample = NUM_W'(sum_new);

  assign cur_level  = level_q[ch_q];
  assign cur_target = target_q[ch_q];
  assign cur_cd     = cd_q[ch_q];
  assign ch_last    = (ch_q == CH_W'(CHANNELS - 1));

  assign num_reload = NUM_W'({reload_q[ch_q], 10'b0}) - NUM_W'(reload_q[ch_q]);
  assign den_speed  = DEN_W'(SPEED_FULL) + DEN_W'(speed_q) * DEN_W'(SPEED_GAIN);

  assign trial      = {rem_q, quo_q[QUO_W-1]};
  assign trial_ge   = (trial >= {1'b0, div_q});
  assign trial_diff = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      for (int c = 0; c < CHANNELS; c++) begin
        level_q[c]  <= '0;
        target_q[c] <= '0;
        cd_q[c]     <= '0;
        reload_q[c] <= '0;
      end
      sum_q           <= '0;
      count_q         <= '0;
      speed_q         <= '0;
      ch_q            <= '0;
      changed_q       <= 1'b0;
      rem_q           <= '0;
      div_q           <= '0;
      quo_q           <= '0;
      bit_q           <= '0;
      out_valid_q     <= 1'b0;
      lamp_out_q      <= '0;
      level_out_q     <= '0;
      level_changed_q <= 1'b0;
      last_result_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            case (command_i)
              CMD_SET: begin
                for (int c = 0; c < CHANNELS; c++) begin
                  if (32'(lamp_index_i) == c) begin
                    level_q[c]  <= level_in_i;
                    target_q[c] <= target_in_i;
                    cd_q[c]     <= '0;
                    reload_q[c] <= reload_in_i;
                  end
                end
              end
              CMD_SAMPLE: begin
                if (count_new >= (CNT_W + 1)'(SAMPLES_PER_UPDATE)) begin
                  rem_q   <= DEN_W'(num_sample[NUM_W-1:QUO_W]);
                  quo_q   <= num_sample[QUO_W-1:0];
                  div_q   <= DEN_W'(4 * SAMPLES_PER_UPDATE);
                  bit_q   <= '0;
                  state_q <= ST_AVG;
                end else begin
                  sum_q   <= sum_new;
                  count_q <= count_new[CNT_W-1:0];
                end
              end
              CMD_TICK: begin
                ch_q    <= '0;
                state_q <= ST_EVAL;
              end
              default: begin
              end
            endcase
          end
        end
        ST_EVAL: begin
          if (cur_cd != '0) begin
            cd_q[ch_q] <= cur_cd - 16'd1;
            changed_q  <= 1'b0;
            state_q    <= ST_EMIT;
          end else if (cur_level != cur_target) begin
            level_q[ch_q] <= (cur_level > cur_target) ? cur_level - 8'd1 : cur_level + 8'd1;
            changed_q     <= 1'b1;
            rem_q         <= DEN_W'(num_reload[NUM_W-1:QUO_W]);
            quo_q         <= num_reload[QUO_W-1:0];
            div_q         <= den_speed;
            bit_q         <= '0;
            state_q       <= ST_DIV;
          end else begin
            changed_q <= 1'b0;
            state_q   <= ST_EMIT;
          end
        end
        ST_DIV, ST_AVG: begin
          rem_q <= trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
          quo_q <= {quo_q[QUO_W-2:0], trial_ge};
          bit_q <= bit_q + 4'd1;
          if (bit_q == 4'd15) begin
            if (state_q == ST_DIV) begin
              cd_q[ch_q] <= {quo_q[QUO_W-2:0], trial_ge};
              state_q    <= ST_EMIT;
            end else begin
              speed_q <= {quo_q[SPEED_W-2:0], trial_ge};
              sum_q   <= '0;
              count_q <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            lamp_out_q      <= 3'(ch_q);
            level_out_q     <= cur_level;
            level_changed_q <= changed_q;
            last_result_q   <= ch_last;
            if (ch_last) begin
              state_q <= ST_IDLE;
            end else begin
              ch_q    <= ch_q + CH_W'(1);
              state_q <= ST_EVAL;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign lamp_out_o      = lamp_out_q;
  assign level_out_o     = level_out_q;
  assign level_changed_o = level_changed_q;
  assign last_result_o   = last_result_q;

  // The partial remainder always stays below the divisor while a division runs.
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_AVG) |-> (rem_q < div_q))
    else $error("divider remainder reached the divisor");

  a_tick_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && command_i == CMD_TICK) |=> (state_q == ST_EVAL && ch_q == '0))
    else $error("tick did not start at the first channel");

  a_step_reloads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && cur_cd == '0 && cur_level != cur_target) |=>
      (state_q == ST_DIV && changed_q))
    else $error("level step did not start a reload division");

  a_last_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && ch_last) |=>
      (out_valid_q && last_result_q && state_q == ST_IDLE))
    else $error("final channel transfer not flagged");

endmodule

// File: sim/tb_multi_channel_led_fade_ramp.sv
// Self-checking testbench for the multi-channel LED fade ramp with speed scaling.
`timescale 1ns / 100ps

module tb_multi_channel_led_fade_ramp;
  import mclf_pkg::*;

  localparam int          LAMPS          = 6;
  localparam int          GROUP_SAMPLES  = 20;
  localparam int          QUIET_LIMIT    = 4000;
  localparam int          SETTLE_CYCLES  = 150;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [2:0]  lamp;
    logic [7:0]  level;
    logic [7:0]  target;
    logic [15:0] period;
    logic [11:0] pot;
  } lamp_cmd_t;

  typedef struct {
    logic [2:0] lamp;
    logic [7:0] level;
    logic       changed;
    logic       last;
  } lamp_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = CMD_TICK;
  logic [2:0]  lamp_index_i = '0;
  logic [7:0]  level_in_i = '0;
  logic [7:0]  target_in_i = '0;
  logic [15:0] reload_in_i = '0;
  logic [11:0] pot_sample_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  lamp_out_o;
  logic [7:0]  level_out_o;
  logic        level_changed_o;
  logic        last_result_o;

  logic [7:0]  lamp_level_q[LAMPS];
  logic [7:0]  lamp_target_q[LAMPS];
  logic [15:0] lamp_countdown_q[LAMPS];
  logic [15:0] lamp_period_q[LAMPS];
  logic [16:0] pot_sum_q;
  int unsigned pot_count_q;
  logic [9:0]  speed_q;

  lamp_report_t pending_reports[$];
  int unsigned  error_count = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  rx_hold_cycles = 0;
  bit           tx_steady = 1'b0;
  bit           rx_steady = 1'b0;

  multi_channel_led_fade_ramp u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .lamp_index_i   (lamp_index_i),
    .level_in_i     (level_in_i),
    .target_in_i    (target_in_i),
    .reload_in_i    (reload_in_i),
    .pot_sample_i   (pot_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .lamp_out_o     (lamp_out_o),
    .level_out_o    (level_out_o),
    .level_changed_o(level_changed_o),
    .last_result_o  (last_result_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [15:0] scale_period(logic [15:0] period, logic [9:0] speed);
    int unsigned num;
    int unsigned den;
    num = period * SPEED_FULL;
    den = SPEED_FULL + SPEED_GAIN * speed;
    return 16'(num / den);
  endfunction

  task automatic apply_lamp_command(input lamp_cmd_t c);
    lamp_report_t r;
    logic         stepped;
    case (c.cmd)
      CMD_SET: begin
        if (c.lamp < LAMPS) begin
          lamp_level_q[c.lamp]     = c.level;
          lamp_target_q[c.lamp]    = c.target;
          lamp_countdown_q[c.lamp] = '0;
          lamp_period_q[c.lamp]    = c.period;
        end
      end
      CMD_SAMPLE: begin
        pot_sum_q   = pot_sum_q + c.pot;
        pot_count_q = pot_count_q + 1;
        if (pot_count_q >= GROUP_SAMPLES) begin
          speed_q     = 10'((pot_sum_q / GROUP_SAMPLES) >> 2);
          pot_sum_q   = '0;
          pot_count_q = 0;
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < LAMPS; i++) begin
          stepped = 1'b0;
          if (lamp_countdown_q[i] != 0) begin
            lamp_countdown_q[i] = lamp_countdown_q[i] - 1'b1;
          end else if (lamp_level_q[i] != lamp_target_q[i]) begin
            if (lamp_level_q[i] > lamp_target_q[i]) begin
              lamp_level_q[i] = lamp_level_q[i] - 1'b1;
            end else begin
              lamp_level_q[i] = lamp_level_q[i] + 1'b1;
            end
            lamp_countdown_q[i] = scale_period(lamp_period_q[i], speed_q);
            stepped = 1'b1;
          end
          r.lamp    = 3'(i);
          r.level   = lamp_level_q[i];
          r.changed = stepped;
          r.last    = (i == LAMPS - 1);
          pending_reports.push_back(r);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $realtime, msg);
    error_count++;
  endtask

  function automatic lamp_cmd_t noise_cmd(logic [1:0] cmd);
    lamp_cmd_t c;
    c.cmd    = cmd;
    c.lamp   = 3'($urandom);
    c.level  = 8'($urandom);
    c.target = 8'($urandom);
    c.period = 16'($urandom);
    c.pot    = 12'($urandom);
    return c;
  endfunction

  function automatic lamp_cmd_t set_cmd(logic [2:0] lamp, logic [7:0] level,
                                        logic [7:0] target, logic [15:0] period);
    lamp_cmd_t c;
    c        = noise_cmd(CMD_SET);
    c.lamp   = lamp;
    c.level  = level;
    c.target = target;
    c.period = period;
    return c;
  endfunction

  function automatic lamp_cmd_t sample_cmd(logic [11:0] pot);
    lamp_cmd_t c;
    c     = noise_cmd(CMD_SAMPLE);
    c.pot = pot;
    return c;
  endfunction

  function automatic lamp_cmd_t random_cmd();
    lamp_cmd_t   c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c = noise_cmd(CMD_TICK);
    end else if (pick < 65) begin
      c = noise_cmd(CMD_SET);
      if ($urandom_range(0, 3) != 0) begin
        c.lamp   = 3'($urandom_range(0, LAMPS - 1));
        c.target = 8'(c.level + $urandom_range(0, 8) - 4);
      end
      if ($urandom_range(0, 4) != 0) begin
        c.period = 16'($urandom_range(0, 7));
      end
    end else if (pick < 94) begin
      c = noise_cmd(CMD_SAMPLE);
    end else begin
      c = noise_cmd(CMD_UNUSED);
    end
    return c;
  endfunction

  task automatic send_item(input lamp_cmd_t c);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i    <= c.cmd;
    lamp_index_i <= c.lamp;
    level_in_i   <= c.level;
    target_in_i  <= c.target;
    reload_in_i  <= c.period;
    pot_sample_i <= c.pot;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    apply_lamp_command(c);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_item(set_cmd(3'd0, 8'd0, 8'd255, 16'd0));
    send_item(set_cmd(3'd5, 8'd255, 8'd0, 16'hFFFF));
    send_item(set_cmd(3'd1, 8'd128, 8'd128, 16'd3));
    send_item(set_cmd(3'd2, 8'd0, 8'd3, 16'd2));
    send_item(set_cmd(3'd3, 8'd200, 8'd198, 16'd1));
    send_item(set_cmd(3'd4, 8'd17, 8'd17, 16'd0));
    send_item(set_cmd(3'd6, 8'hFF, 8'hFF, 16'hFFFF));
    send_item(set_cmd(3'd7, 8'h55, 8'hAA, 16'h5A5A));
    send_item(noise_cmd(CMD_UNUSED));
    repeat (8) send_item(noise_cmd(CMD_TICK));
    send_item(set_cmd(3'd5, 8'd10, 8'd12, 16'd1));
    repeat (3) send_item(noise_cmd(CMD_TICK));
  endtask

  task automatic test_speed_scaling();
    repeat (GROUP_SAMPLES) send_item(sample_cmd(12'hFFF));
    send_item(set_cmd(3'd0, 8'd40, 8'd0, 16'hFFFF));
    send_item(set_cmd(3'd1, 8'd0, 8'd40, 16'd1000));
    send_item(set_cmd(3'd2, 8'd9, 8'd0, 16'd13));
    repeat (6) send_item(noise_cmd(CMD_TICK));
    repeat (GROUP_SAMPLES) send_item(sample_cmd(12'h000));
    send_item(set_cmd(3'd1, 8'd0, 8'd40, 16'd1000));
    repeat (3) send_item(noise_cmd(CMD_TICK));
  endtask

  task automatic test_random_mix();
    repeat (250) send_item(random_cmd());
  endtask

  task automatic test_no_idling();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (60) send_item(random_cmd());
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_output_backpressure();
    drain_results();
    rx_hold_cycles = 300;
    tx_steady = 1'b1;
    send_item(set_cmd(3'd4, 8'd0, 8'd255, 16'd0));
    repeat (14) send_item(noise_cmd(CMD_TICK));
    tx_steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (5) begin
      repeat (10) send_item(random_cmd());
      drain_results();
    end
  endtask

  initial begin : result_sink
    int unsigned stall_len;
    forever begin
      stall_len = rx_steady ? 0 : $urandom_range(0, 5);
      if (rx_hold_cycles != 0) begin
        stall_len      = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      @(negedge clk_i);
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin : result_check
    lamp_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("result transfer for lamp %0d with nothing predicted",
                                  lamp_out_o));
      end else begin
        want = pending_reports.pop_front();
        if (lamp_out_o !== want.lamp) begin
          report_mismatch($sformatf("lamp_out is %0d, predicted %0d", lamp_out_o, want.lamp));
        end
        if (level_out_o !== want.level) begin
          report_mismatch($sformatf("lamp %0d level_out is %0d, predicted %0d",
                                    want.lamp, level_out_o, want.level));
        end
        if (level_changed_o !== want.changed) begin
          report_mismatch($sformatf("lamp %0d level_changed is %b, predicted %b",
                                    want.lamp, level_changed_o, want.changed));
        end
        if (last_result_o !== want.last) begin
          report_mismatch($sformatf("lamp %0d last_result is %b, predicted %b",
                                    want.lamp, last_result_o, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles", $realtime, QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < LAMPS; i++) begin
      lamp_level_q[i]     = '0;
      lamp_target_q[i]    = '0;
      lamp_countdown_q[i] = '0;
      lamp_period_q[i]    = '0;
    end
    pot_sum_q   = '0;
    pot_count_q = 0;
    speed_q     = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_speed_scaling();
    test_random_mix();
    test_no_idling();
    test_output_backpressure();
    test_drain_pause();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_reports.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived", pending_reports.size()));
    end
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
